### hw/rtl/mer_pkg.sv
// mer_pkg: shared types and default sizes for the midpoint ellipse rasterizer
// used by mer_alu, mer_seq and midpoint_ellipse_rasterizer; no dependencies
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int AXIS_BITS_DEF  = 10;
  localparam int COLOR_BITS     = 8;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    mul_en;
  } alu_ctl_t;

  typedef struct packed {
    logic req;
    logic blank;
    logic last;
  } emit_t;

endpackage

`default_nettype wire

### hw/rtl/mer_alu.sv
// mer_alu: shared add/subtract unit and registered multiplier
// depends on mer_pkg
`default_nettype none

module mer_alu #(
  parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF,
  localparam int MW = 2 * AXIS_BITS + 4,
  localparam int PW = 2 * MW
) (
  input  wire logic            clk,
  input  mer_pkg::alu_ctl_t    ctl,
  input  logic signed [PW-1:0] add_a,
  input  logic signed [PW-1:0] add_b,
  output logic signed [PW-1:0] sum,
  input  logic [MW-1:0]        mul_a,
  input  logic [MW-1:0]        mul_b,
  output logic [PW-1:0]        prod
);

  always_comb begin
    unique case (ctl.op)
      mer_pkg::ALU_ADD: sum = add_a + add_b;
      mer_pkg::ALU_SUB: sum = add_a - add_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mer_seq.sv
// mer_seq: sequencer and ellipse state registers, drives the shared mer_alu
// depends on mer_pkg and mer_alu
`default_nettype none

module mer_seq #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  localparam int XW = AXIS_BITS + 1,
  localparam int SW = 3 * AXIS_BITS + 2,
  localparam int MW = 2 * AXIS_BITS + 4,
  localparam int DW = 2 * MW
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [COORD_BITS-1:0]           center_x,
  input  logic [COORD_BITS-1:0]           center_y,
  input  logic [AXIS_BITS-1:0]            semi_axis_x,
  input  logic [AXIS_BITS-1:0]            semi_axis_y,
  input  logic [mer_pkg::COLOR_BITS-1:0]  pixel_color,
  output mer_pkg::emit_t                  emit,
  input  logic                            emit_ack,
  output logic [COORD_BITS-1:0]           cx,
  output logic [COORD_BITS-1:0]           cy,
  output logic [mer_pkg::COLOR_BITS-1:0]  color,
  output logic [XW-1:0]                   x,
  output logic [AXIS_BITS-1:0]            y
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_SQA    = 18'h00002,
    S_SQB    = 18'h00004,
    S_FY     = 18'h00008,
    S_D0     = 18'h00010,
    S_D1     = 18'h00020,
    S_R2_TX  = 18'h00040,
    S_R2_TY  = 18'h00080,
    S_R2_ATY = 18'h00100,
    S_R2_BTX = 18'h00200,
    S_R2_AB  = 18'h00400,
    S_R2_D   = 18'h00800,
    S_STEP_A = 18'h01000,
    S_STEP_B = 18'h02000,
    S_STEP_C = 18'h04000,
    S_STEP_D = 18'h08000,
    S_STEP_E = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

  state_t state, state_next;

  logic [COORD_BITS-1:0]          cx_next, cy_next;
  logic [mer_pkg::COLOR_BITS-1:0] color_next;
  logic [XW-1:0]                  x_next;
  logic [AXIS_BITS-1:0]           y_next;
  logic [2*AXIS_BITS-1:0]         asq, asq_next, bsq, bsq_next;
  logic [SW-1:0]                  fx, fx_next, fy, fy_next;
  logic signed [DW-1:0]           d, d_next, tmp, tmp_next;
  logic                           region2, region2_next;
  logic                           finished, finished_next;
  logic                           blank, blank_next;

  mer_pkg::alu_ctl_t    alu_ctl;
  logic signed [DW-1:0] add_a, add_b, sum;
  logic [MW-1:0]        mul_a, mul_b;
  logic [DW-1:0]        prod;

  logic signed [DW-1:0] asq_w, bsq_w, fx_w, fy_w, prod_w;
  logic                 short_path, accept, start_req;

  mer_alu #(.AXIS_BITS(AXIS_BITS)) u_alu (
    .clk   (clk),
    .ctl   (alu_ctl),
    .add_a (add_a),
    .add_b (add_b),
    .sum   (sum),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign asq_w  = DW'(asq);
  assign bsq_w  = DW'(bsq);
  assign fx_w   = DW'(fx);
  assign fy_w   = DW'(fy);
  assign prod_w = prod;

  // region 1 takes the short path when d < 0, region 2 when d >= 0
  assign short_path = region2 ? !d[DW-1] : d[DW-1];

  assign in_stall  = (state != S_IDLE);
  assign accept    = (state == S_IDLE) && in_valid;
  assign start_req = accept && (mode == mer_pkg::MODE_START);

  assign emit.req   = (state == S_EMIT);
  assign emit.blank = blank;
  assign emit.last  = !blank && (y == '0);

  always_comb begin
    state_next    = state;
    cx_next       = cx;
    cy_next       = cy;
    color_next    = color;
    x_next        = x;
    y_next        = y;
    asq_next      = asq;
    bsq_next      = bsq;
    fx_next       = fx;
    fy_next       = fy;
    d_next        = d;
    tmp_next      = tmp;
    region2_next  = region2;
    finished_next = finished;
    blank_next    = blank;
    alu_ctl.op     = mer_pkg::ALU_ADD;
    alu_ctl.mul_en = 1'b0;
    add_a         = '0;
    add_b         = '0;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == mer_pkg::MODE_START) begin
            cx_next       = center_x;
            cy_next       = center_y;
            color_next    = pixel_color;
            y_next        = semi_axis_y;
            asq_next      = (2*AXIS_BITS)'(semi_axis_x);
            x_next        = '0;
            fx_next       = '0;
            region2_next  = 1'b0;
            finished_next = 1'b0;
            blank_next    = 1'b0;
            state_next    = S_SQA;
          end else if (finished) begin
            blank_next = 1'b1;
            state_next = S_EMIT;
          end else if (!region2 && (fx >= fy)) begin
            region2_next = 1'b1;
            state_next   = S_R2_TX;
          end else begin
            state_next = S_STEP_A;
          end
        end
      end
      // start: a^2, b^2, fy = 2a^2 b, d = 4b^2 + a^2 - 2fy
      S_SQA: begin
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(asq);
        mul_b          = MW'(asq);
        state_next     = S_SQB;
      end
      S_SQB: begin
        asq_next       = prod[2*AXIS_BITS-1:0];
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(y);
        mul_b          = MW'(y);
        state_next     = S_FY;
      end
      S_FY: begin
        bsq_next       = prod[2*AXIS_BITS-1:0];
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(asq);
        mul_b          = MW'(y);
        state_next     = S_D0;
      end
      S_D0: begin
        fy_next    = {prod[SW-2:0], 1'b0};
        add_a      = bsq_w <<< 2;
        add_b      = asq_w;
        d_next     = sum;
        state_next = S_D1;
      end
      S_D1: begin
        alu_ctl.op = mer_pkg::ALU_SUB;
        add_a      = d;
        add_b      = fy_w <<< 1;
        d_next     = sum;
        state_next = S_EMIT;
      end
      // region 2 entry: d = b^2 (2x+1)^2 + 4a^2 (y-1)^2 - 4a^2 b^2
      S_R2_TX: begin
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'({x, 1'b1});
        mul_b          = MW'({x, 1'b1});
        state_next     = S_R2_TY;
      end
      S_R2_TY: begin
        tmp_next       = prod_w;
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(y - 1'b1);
        mul_b          = MW'(y - 1'b1);
        state_next     = S_R2_ATY;
      end
      S_R2_ATY: begin
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(asq);
        mul_b          = prod[MW-1:0];
        state_next     = S_R2_BTX;
      end
      S_R2_BTX: begin
        add_a          = prod_w <<< 2;
        d_next         = sum;
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(bsq);
        mul_b          = tmp[MW-1:0];
        state_next     = S_R2_AB;
      end
      S_R2_AB: begin
        add_a          = d;
        add_b          = prod_w;
        d_next         = sum;
        alu_ctl.mul_en = 1'b1;
        mul_a          = MW'(asq);
        mul_b          = MW'(bsq);
        state_next     = S_R2_D;
      end
      S_R2_D: begin
        alu_ctl.op = mer_pkg::ALU_SUB;
        add_a      = d;
        add_b      = prod_w <<< 2;
        d_next     = sum;
        state_next = S_STEP_A;
      end
      // point step
      S_STEP_A: begin
        if (!region2) begin
          x_next  = x + 1'b1;
          add_a   = fx_w;
          add_b   = bsq_w <<< 1;
          fx_next = sum[SW-1:0];
        end else begin
          y_next     = y - 1'b1;
          alu_ctl.op = mer_pkg::ALU_SUB;
          add_a      = fy_w;
          add_b      = asq_w <<< 1;
          fy_next    = sum[SW-1:0];
        end
        state_next = S_STEP_B;
      end
      S_STEP_B: begin
        if (short_path) begin
          if (region2) begin
            alu_ctl.op = mer_pkg::ALU_SUB;
            add_a      = asq_w;
            add_b      = fy_w;
          end else begin
            add_a = fx_w;
            add_b = bsq_w;
          end
          tmp_next   = sum;
          state_next = S_STEP_E;
        end else begin
          if (!region2) begin
            y_next     = y - 1'b1;
            alu_ctl.op = mer_pkg::ALU_SUB;
            add_a      = fy_w;
            add_b      = asq_w <<< 1;
            fy_next    = sum[SW-1:0];
          end else begin
            x_next  = x + 1'b1;
            add_a   = fx_w;
            add_b   = bsq_w <<< 1;
            fx_next = sum[SW-1:0];
          end
          state_next = S_STEP_C;
        end
      end
      S_STEP_C: begin
        alu_ctl.op = mer_pkg::ALU_SUB;
        add_a      = fx_w;
        add_b      = fy_w;
        tmp_next   = sum;
        state_next = S_STEP_D;
      end
      S_STEP_D: begin
        add_a      = tmp;
        add_b      = region2 ? asq_w : bsq_w;
        tmp_next   = sum;
        state_next = S_STEP_E;
      end
      S_STEP_E: begin
        add_a      = d;
        add_b      = tmp <<< 2;
        d_next     = sum;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ack) begin
          if (!blank && (y == '0)) begin
            finished_next = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      region2  <= 1'b0;
      finished <= 1'b1;
      blank    <= 1'b0;
    end else begin
      state    <= state_next;
      region2  <= region2_next;
      finished <= finished_next;
      blank    <= blank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx    <= '0;
      cy    <= '0;
      color <= '0;
      x     <= '0;
      y     <= '0;
      asq   <= '0;
      bsq   <= '0;
      fx    <= '0;
      fy    <= '0;
      d     <= '0;
      tmp   <= '0;
    end else begin
      cx    <= cx_next;
      cy    <= cy_next;
      color <= color_next;
      x     <= x_next;
      y     <= y_next;
      asq   <= asq_next;
      bsq   <= bsq_next;
      fx    <= fx_next;
      fy    <= fy_next;
      d     <= d_next;
      tmp   <= tmp_next;
    end
  end

  a_start_clears_finished: assert property (@(posedge clk) disable iff (rst)
    start_req |=> !finished)
    else $error("finished still set after start request");

  a_last_sets_finished: assert property (@(posedge clk) disable iff (rst)
    (emit.req && emit_ack && emit.last) |=> finished)
    else $error("last point did not end the ellipse");

  a_region2_sticky: assert property (@(posedge clk) disable iff (rst)
    (region2 && !start_req) |=> region2)
    else $error("left region 2 without a start request");

  a_y_never_grows: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (y <= $past(y)))
    else $error("y offset increased during a step");

endmodule

`default_nettype wire

### hw/rtl/midpoint_ellipse_rasterizer.sv
// midpoint_ellipse_rasterizer: top level, request handshake and result register
// depends on mer_pkg, mer_seq (which holds mer_alu)
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  mode, center_x, center_y, semi_axis_x,
//                                           semi_axis_y, pixel_color
//  out      output     out_valid/out_stall  right_x, left_x, lower_y, upper_y,
//                                           out_color, point_valid, last_point
//
// one request at a time; every arithmetic step goes through one shared adder,
// products through one registered multiplier
// start request: S_SQA, S_SQB, S_FY, S_D0, S_D1; a step: S_STEP_A, S_STEP_B, then
// S_STEP_E when the decision keeps direction, or S_STEP_C, S_STEP_D, S_STEP_E when
// both offsets move; entering region 2 first runs the multiply states; a step with
// no active ellipse gives a blank result; synchronous reset leaves no ellipse active;
// a stalled result does not block the next request until its own result is ready
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  localparam int OUT_W = COORD_BITS + 2,
  localparam int XW    = AXIS_BITS + 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              mode,
  input  wire logic [COORD_BITS-1:0]             center_x,
  input  wire logic [COORD_BITS-1:0]             center_y,
  input  wire logic [AXIS_BITS-1:0]              semi_axis_x,
  input  wire logic [AXIS_BITS-1:0]              semi_axis_y,
  input  wire logic [mer_pkg::COLOR_BITS-1:0]    pixel_color,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [OUT_W-1:0]                right_x,
  output logic signed [OUT_W-1:0]                left_x,
  output logic signed [OUT_W-1:0]                lower_y,
  output logic signed [OUT_W-1:0]                upper_y,
  output logic [mer_pkg::COLOR_BITS-1:0]         out_color,
  output logic                                   point_valid,
  output logic                                   last_point
);

  mer_pkg::emit_t                  emit;
  logic                            emit_ack;
  logic [COORD_BITS-1:0]           cx, cy;
  logic [mer_pkg::COLOR_BITS-1:0]  color;
  logic [XW-1:0]                   x;
  logic [AXIS_BITS-1:0]            y;
  logic signed [OUT_W-1:0]         cx_w, cy_w, x_w, y_w;

  mer_seq #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .center_x    (center_x),
    .center_y    (center_y),
    .semi_axis_x (semi_axis_x),
    .semi_axis_y (semi_axis_y),
    .pixel_color (pixel_color),
    .emit        (emit),
    .emit_ack    (emit_ack),
    .cx          (cx),
    .cy          (cy),
    .color       (color),
    .x           (x),
    .y           (y)
  );

  assign emit_ack = !out_valid || !out_stall;

  assign cx_w = OUT_W'(cx);
  assign cy_w = OUT_W'(cy);
  assign x_w  = OUT_W'(x);
  assign y_w  = OUT_W'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.req && emit_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.req && emit_ack) begin
      if (emit.blank) begin
        right_x     <= '0;
        left_x      <= '0;
        lower_y     <= '0;
        upper_y     <= '0;
        out_color   <= '0;
        point_valid <= 1'b0;
        last_point  <= 1'b0;
      end else begin
        right_x     <= cx_w + x_w;
        left_x      <= cx_w - x_w;
        lower_y     <= cy_w + y_w;
        upper_y     <= cy_w - y_w;
        out_color   <= color;
        point_valid <= 1'b1;
        last_point  <= emit.last;
      end
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_midpoint_ellipse_rasterizer.sv
// tb_midpoint_ellipse_rasterizer: self-checking bench for the midpoint ellipse rasterizer;
// predicts every point with its own integer tracer, random idling on both channels
// depends on mer_pkg and midpoint_ellipse_rasterizer
`default_nettype none

module tb_midpoint_ellipse_rasterizer;

  localparam int COORD_W   = mer_pkg::COORD_BITS_DEF;
  localparam int AXIS_W    = mer_pkg::AXIS_BITS_DEF;
  localparam int COLOR_W   = mer_pkg::COLOR_BITS;
  localparam int OUT_W     = COORD_W + 2;
  localparam int ITEMS     = 1250;
  localparam int TAIL_CALM = 150;

  typedef struct {
    mer_pkg::mode_t      mode;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [AXIS_W-1:0]   ax;
    logic [AXIS_W-1:0]   ay;
    logic [COLOR_W-1:0]  color;
    bit                  drain_first;
  } ellipse_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] lower_y;
    logic signed [OUT_W-1:0] upper_y;
    logic [COLOR_W-1:0]      color;
    logic                    point_valid;
    logic                    last_point;
  } pixel_quad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_mode = 1'b0;
  logic [COORD_W-1:0]    req_cx = '0;
  logic [COORD_W-1:0]    req_cy = '0;
  logic [AXIS_W-1:0]     req_ax = '0;
  logic [AXIS_W-1:0]     req_ay = '0;
  logic [COLOR_W-1:0]    req_color = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [OUT_W-1:0] right_x, left_x, lower_y, upper_y;
  logic [COLOR_W-1:0]    out_color;
  logic                  point_valid, last_point;

  ellipse_req_t pending_reqs[$];
  pixel_quad_t  expected_quads[$];
  ellipse_req_t cur_req;
  bit           drain_next = 0;
  bit           calm = 0;
  int           mismatches = 0;
  int           sent = 0;
  int           received = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           in_idle_pct = 30;
  int           out_idle_pct = 30;

  // tracer state
  longint trace_col, trace_row, trace_x, trace_y;
  longint a_sq, b_sq, grad_x, grad_y, mid_err;
  logic [COLOR_W-1:0] trace_color;
  bit     lower_arc, trace_done;

  midpoint_ellipse_rasterizer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (req_mode),
    .center_x    (req_cx),
    .center_y    (req_cy),
    .semi_axis_x (req_ax),
    .semi_axis_y (req_ay),
    .pixel_color (req_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .right_x     (right_x),
    .left_x      (left_x),
    .lower_y     (lower_y),
    .upper_y     (upper_y),
    .out_color   (out_color),
    .point_valid (point_valid),
    .last_point  (last_point)
  );

  always #5 clk = ~clk;

  function automatic void clear_trace();
    trace_col = 0; trace_row = 0; trace_x = 0; trace_y = 0;
    a_sq = 0; b_sq = 0; grad_x = 0; grad_y = 0; mid_err = 0;
    trace_color = '0; lower_arc = 0; trace_done = 1;
  endfunction

  function automatic pixel_quad_t trace_point(input ellipse_req_t r);
    pixel_quad_t p;
    longint a, b, tx, ty;
    p.right_x = '0; p.left_x = '0; p.lower_y = '0; p.upper_y = '0;
    p.color = '0; p.point_valid = 1'b0; p.last_point = 1'b0;
    if (r.mode == mer_pkg::MODE_STEP && trace_done) begin
      return p;
    end
    if (r.mode == mer_pkg::MODE_START) begin
      a = longint'(r.ax);
      b = longint'(r.ay);
      trace_col = longint'(r.cx);
      trace_row = longint'(r.cy);
      trace_color = r.color;
      a_sq = a * a;
      b_sq = b * b;
      trace_x = 0;
      trace_y = b;
      grad_x = 0;
      grad_y = 2 * a_sq * b;
      mid_err = 4 * b_sq - 4 * a_sq * b + a_sq;
      lower_arc = 0;
      trace_done = 0;
    end else begin
      // region change loads the second decision term first
      if (!lower_arc && grad_x >= grad_y) begin
        tx = 2 * trace_x + 1;
        ty = trace_y - 1;
        lower_arc = 1;
        mid_err = b_sq * tx * tx + 4 * a_sq * ty * ty - 4 * a_sq * b_sq;
      end
      if (lower_arc) begin
        trace_y--;
        grad_y -= 2 * a_sq;
        if (mid_err >= 0) begin
          mid_err += 4 * (a_sq - grad_y);
        end else begin
          trace_x++;
          grad_x += 2 * b_sq;
          mid_err += 4 * (grad_x - grad_y + a_sq);
        end
      end else begin
        trace_x++;
        grad_x += 2 * b_sq;
        if (mid_err < 0) begin
          mid_err += 4 * (grad_x + b_sq);
        end else begin
          trace_y--;
          grad_y -= 2 * a_sq;
          mid_err += 4 * (grad_x - grad_y + b_sq);
        end
      end
    end
    p.right_x = OUT_W'(trace_col + trace_x);
    p.left_x = OUT_W'(trace_col - trace_x);
    p.lower_y = OUT_W'(trace_row + trace_y);
    p.upper_y = OUT_W'(trace_row - trace_y);
    p.color = trace_color;
    p.point_valid = 1'b1;
    p.last_point = (trace_y == 0);
    if (trace_y == 0) trace_done = 1;
    return p;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void add_request(input mer_pkg::mode_t m, input int cx, input int cy,
                                      input int ax, input int ay, input int color);
    ellipse_req_t r;
    r.mode = m;
    r.cx = COORD_W'(cx);
    r.cy = COORD_W'(cy);
    r.ax = AXIS_W'(ax);
    r.ay = AXIS_W'(ay);
    r.color = COLOR_W'(color);
    r.drain_first = drain_next;
    drain_next = 0;
    pending_reqs.push_back(r);
  endfunction

  // step fields carry random content that the block must ignore
  function automatic void add_steps(input int n);
    for (int i = 0; i < n; i++) begin
      add_request(mer_pkg::MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    ellipse_req_t nxt;
    bit take;
    take = 0;
    if (rst) begin
      in_valid <= 1'b0;
      clear_trace();
    end else begin
      if (in_valid && !in_stall) begin
        expected_quads.push_back(trace_point(cur_req));
        sent++;
        if (sent % 100 == 0) in_idle_pct = $urandom_range(0, 3) * 15;
      end
      calm = pending_reqs.size() < TAIL_CALM;
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() > 0) begin
          if (!pending_reqs[0].drain_first || expected_quads.size() == 0) begin
            if (!calm && $urandom_range(99) < in_idle_pct) in_gap = $urandom_range(0, 6);
            else take = 1;
          end
        end
        if (take) begin
          nxt = pending_reqs.pop_front();
          cur_req = nxt;
          req_mode <= nxt.mode;
          req_cx <= nxt.cx;
          req_cy <= nxt.cy;
          req_ax <= nxt.ax;
          req_ay <= nxt.ay;
          req_color <= nxt.color;
        end
        in_valid <= take;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_quad_t want;
    bit hold;
    hold = 0;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_quads.size() == 0) begin
          mismatches++;
          $display("%0t: point with none expected, got x %0d/%0d y %0d/%0d", $time,
                   right_x, left_x, lower_y, upper_y);
        end else begin
          want = expected_quads.pop_front();
          check_field("right_x", want.right_x, right_x);
          check_field("left_x", want.left_x, left_x);
          check_field("lower_y", want.lower_y, lower_y);
          check_field("upper_y", want.upper_y, upper_y);
          check_field("out_color", want.color, out_color);
          check_field("point_valid", want.point_valid, point_valid);
          check_field("last_point", want.last_point, last_point);
        end
        received++;
        if (received % 100 == 0) out_idle_pct = $urandom_range(0, 3) * 15;
      end
      if (out_gap > 0) begin
        out_gap--;
        hold = 1;
      end else if (!calm && $urandom_range(99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 6);
        hold = 1;
      end
      out_stall <= hold;
    end
  end

  initial begin
    int kind, a, b, lim;
    bit mid_drain;
    mid_drain = 0;

    // directed: idle step, zero axes, center column, region change, extremes
    add_steps(1);
    add_request(mer_pkg::MODE_START, 2047, 2047, 0, 0, 255);
    add_steps(1);
    add_request(mer_pkg::MODE_START, 0, 0, 0, 3, 0);
    add_steps(5);
    add_request(mer_pkg::MODE_START, 1000, 5, 3, 2, 8'hA5);
    add_steps(6);
    add_request(mer_pkg::MODE_START, 0, 2047, 1023, 1023, 8'h5A);
    add_steps(2);
    add_request(mer_pkg::MODE_START, 2047, 0, 1023, 1, 8'hC3);
    add_steps(2);

    drain_next = 1;
    while (pending_reqs.size() < ITEMS) begin
      if (!mid_drain && pending_reqs.size() > ITEMS / 2) begin
        drain_next = 1;
        mid_drain = 1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        add_request(mer_pkg::mode_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      end else if (kind == 1) begin
        // large axes, cut short by the next start
        add_request(mer_pkg::MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom);
        add_steps($urandom_range(0, 40));
      end else begin
        lim = ($urandom_range(0, 4) == 0) ? 60 : 20;
        a = $urandom_range(0, lim);
        b = $urandom_range(0, lim);
        add_request(mer_pkg::MODE_START, $urandom, $urandom, a, b, $urandom);
        add_steps(a + b + $urandom_range(1, 3));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_quads.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_quads.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
